@@ hw/rtl/subscriber_timer_table_defines.svh @@
// Assertion macros used by the timer table control logic.
`ifndef SUBSCRIBER_TIMER_TABLE_DEFINES_SVH
`define SUBSCRIBER_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
// Types, codes and sizes shared by the subscriber timer table.
package stt_pkg;

  localparam int CLIENT_SLOTS = 16;
  localparam int IDX_W        = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int SLOT_W       = 4;
  localparam int TAG_W        = 16;
  localparam int PERIOD_W     = 32;
  localparam int CFG_W        = 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENT_SLOTS - 1);

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SUBSCRIBE = 3'd1,
    OP_CREATE    = 3'd2,
    OP_EXIT      = 3'd3,
    OP_DELETE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SHORT   = 2'd2,
    ST_EXISTS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_END
  } state_t;

  // One timer entry as kept in the table memory.
  typedef struct packed {
    logic                periodic;
    logic [TAG_W-1:0]    tag;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]          op;
    logic [SLOT_W-1:0]   slot;
    logic                periodic;
    logic [TAG_W-1:0]    tag;
    logic [PERIOD_W-1:0] period;
  } item_t;

  typedef struct packed {
    logic              kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } result_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wdata;
  } ram_req_t;

endpackage

@@ hw/rtl/stt_ram.sv @@
// Simple dual-port RAM with registered read.
module stt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/stt_ctrl.sv @@
// Event decoder, client flags and tick scan sequencer of the timer table.
`include "subscriber_timer_table_defines.svh"

module stt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [stt_pkg::CFG_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  stt_pkg::item_t         item,
  output stt_pkg::ram_req_t      ram_req,
  input  stt_pkg::entry_t        rdata,
  input  logic                   out_free,
  output logic                   emit,
  output stt_pkg::result_t       res
);

  stt_pkg::state_t                  state, state_next;
  logic [stt_pkg::IDX_W-1:0]        idx;
  logic [stt_pkg::CFG_W-1:0]        min_period;
  logic [stt_pkg::CLIENT_SLOTS-1:0] known, active, present;
  stt_pkg::status_t                 held_status;

  stt_pkg::status_t                 status;
  stt_pkg::op_t                     op;
  logic [stt_pkg::IDX_W-1:0]        slot_idx;
  logic                             in_range, take;
  logic                             eligible, hit, stall, advance, last_slot;
  logic [stt_pkg::PERIOD_W-1:0]     elapsed_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == stt_pkg::S_IDLE);
  assign take      = in_valid && in_ready;
  assign op        = stt_pkg::op_t'(item.op);
  assign slot_idx  = stt_pkg::IDX_W'(item.slot);
  assign in_range  = (32'(item.slot) < stt_pkg::CLIENT_SLOTS);

  assign eligible    = known[idx] && active[idx] && present[idx];
  assign elapsed_inc = rdata.elapsed + 1'b1;
  assign hit         = eligible && (elapsed_inc == rdata.period);
  // hold the scan while an expiry cannot be handed to the output
  assign stall       = hit && !out_free;
  assign advance     = (state == stt_pkg::S_SCAN) && !stall;
  assign last_slot   = (idx == stt_pkg::LAST_IDX);

  always_comb begin
    status = stt_pkg::ST_OK;
    case (op)
      stt_pkg::OP_SUBSCRIBE: begin
        if (!in_range || !known[slot_idx]) begin
          status = stt_pkg::ST_UNKNOWN;
        end else if (item.period < 32'(min_period)) begin
          status = stt_pkg::ST_SHORT;
        end else if (present[slot_idx]) begin
          status = stt_pkg::ST_EXISTS;
        end
      end
      stt_pkg::OP_CREATE: begin
        if (!in_range) begin
          status = stt_pkg::ST_UNKNOWN;
        end
      end
      stt_pkg::OP_EXIT, stt_pkg::OP_DELETE: begin
        if (!in_range || !known[slot_idx]) begin
          status = stt_pkg::ST_UNKNOWN;
        end
      end
      default: status = stt_pkg::ST_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      stt_pkg::S_IDLE: begin
        if (take) begin
          state_next = (op == stt_pkg::OP_TICK) ? stt_pkg::S_SCAN : stt_pkg::S_EXEC;
        end
      end
      stt_pkg::S_EXEC: begin
        if (out_free) state_next = stt_pkg::S_IDLE;
      end
      stt_pkg::S_SCAN: begin
        if (advance && last_slot) state_next = stt_pkg::S_END;
      end
      stt_pkg::S_END: begin
        if (out_free) state_next = stt_pkg::S_IDLE;
      end
      default: state_next = stt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_req = '0;
    emit    = 1'b0;
    res     = '0;
    case (state)
      stt_pkg::S_IDLE: begin
        if (take && op == stt_pkg::OP_TICK) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = '0;
        end else if (take && op == stt_pkg::OP_SUBSCRIBE && status == stt_pkg::ST_OK) begin
          ram_req.wr_en            = 1'b1;
          ram_req.wr_addr          = slot_idx;
          ram_req.wdata.periodic   = item.periodic;
          ram_req.wdata.tag        = item.tag;
          ram_req.wdata.period     = item.period;
          ram_req.wdata.elapsed    = '0;
        end
      end
      stt_pkg::S_EXEC: begin
        emit       = out_free;
        res.status = held_status;
        res.last   = 1'b1;
      end
      stt_pkg::S_SCAN: begin
        if (advance) begin
          // write back the entry under evaluation if eligible, fetch the next one unless last
          ram_req.wr_en         = eligible;
          ram_req.wr_addr       = idx;
          ram_req.wdata         = rdata;
          ram_req.wdata.elapsed = (hit && rdata.periodic) ? '0 : elapsed_inc;
          ram_req.rd_en         = !last_slot;
          ram_req.rd_addr       = idx + 1'b1;
        end
        emit     = hit && out_free;
        res.kind = 1'b1;
        res.slot = stt_pkg::SLOT_W'(idx);
        res.tag  = rdata.tag;
      end
      stt_pkg::S_END: begin
        emit     = out_free;
        res.last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stt_pkg::S_IDLE;
      idx        <= '0;
      min_period <= stt_pkg::CFG_W'(1);
      known      <= '0;
      active     <= '0;
      present    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        min_period <= cfg_data;
      end
      if (take) begin
        held_status <= status;
        case (op)
          stt_pkg::OP_TICK: idx <= '0;
          stt_pkg::OP_SUBSCRIBE: begin
            if (status == stt_pkg::ST_OK) present[slot_idx] <= 1'b1;
          end
          stt_pkg::OP_CREATE: begin
            if (status == stt_pkg::ST_OK) begin
              known[slot_idx]   <= 1'b1;
              active[slot_idx]  <= 1'b1;
              present[slot_idx] <= 1'b0;
            end
          end
          stt_pkg::OP_EXIT: begin
            if (status == stt_pkg::ST_OK) active[slot_idx] <= 1'b0;
          end
          stt_pkg::OP_DELETE: begin
            if (status == stt_pkg::ST_OK) begin
              known[slot_idx]   <= 1'b0;
              active[slot_idx]  <= 1'b0;
              present[slot_idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (advance) begin
        // drop a one-shot timer once it fires
        if (hit && !rdata.periodic) present[idx] <= 1'b0;
        if (!last_slot) idx <= idx + 1'b1;
      end
    end
  end

  `STT_ASSERT_NOW(a_no_rw_clash, ram_req.wr_en && ram_req.rd_en, ram_req.wr_addr != ram_req.rd_addr, "table read and write hit the same entry")
  `STT_ASSERT_NEXT(a_stall_holds_idx, state == stt_pkg::S_SCAN && stall, $stable(idx) && state == stt_pkg::S_SCAN, "scan moved while an expiry was held")
  `STT_ASSERT_NOW(a_timer_needs_client, 1'b1, (present & ~known) == '0, "timer present on an unknown client")
  `STT_ASSERT_NOW(a_emit_has_room, emit, out_free, "result emitted while output register is full")

endmodule

@@ hw/rtl/subscriber_timer_table.sv @@
// Top level of the subscriber timer table: ports, table memory, output register.
//
//  channel  direction  handshake                payload
//  s_*      in         s_tvalid / s_tready      event word (tuser opcode, tdata fields)
//  m_*      out        m_tvalid / m_tready      result word (tuser kind, tlast last)
//  cfg_*    in         cfg_valid / cfg_ready    min_period write, always ready
//
// A non-tick event is accepted, then its status word is sent once the output has room.
// A tick scans the table, then sends a closing last word: the scan reads one table
// entry per cycle unless stalled, over the single read port, while writing back the previous one.
// Output back-pressure freezes the scan on an expiring slot until the word is taken.
// Reset clears the client flags and sets min_period to 1; the timer memory needs no clearing.
module subscriber_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // client_slot[3:0], want_periodic[4], client_tag[20:5],
                                 // period_ticks[52:21], zero fill[55:53]
  input  logic [7:0]  s_tuser,   // opcode[2:0], zero fill[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[1:0], notify_slot[5:2], notify_tag[21:6],
                                 // zero fill[23:22]
  output logic [7:0]  m_tuser,   // kind[0], zero fill[7:1]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  stt_pkg::item_t    item;
  stt_pkg::ram_req_t ram_req;
  stt_pkg::entry_t   rdata;
  stt_pkg::result_t  res, out_res;
  logic [stt_pkg::ENTRY_W-1:0] ram_rdata;
  logic              emit, out_free;

  assign item.op       = s_tuser[2:0];
  assign item.slot     = s_tdata[3:0];
  assign item.periodic = s_tdata[4];
  assign item.tag      = s_tdata[20:5];
  assign item.period   = s_tdata[52:21];

  stt_ram #(
    .DEPTH (stt_pkg::CLIENT_SLOTS),
    .WIDTH (stt_pkg::ENTRY_W),
    .AW    (stt_pkg::IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rdata),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wdata)
  );

  assign rdata = stt_pkg::entry_t'(ram_rdata);

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .ram_req   (ram_req),
    .rdata     (rdata),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.tag, out_res.slot, out_res.status};
  assign m_tuser = {7'b0, out_res.kind};
  assign m_tlast = out_res.last;

endmodule
